// ===== hw/rtl/lsmc_pkg.sv =====
package lsmc_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH     = 32;
    localparam int PATTERN_BYTES   = 8;
    localparam int PATTERN_WIDTH   = 8 * PATTERN_BYTES;
    localparam int LEN_WIDTH       = 4;
    localparam int BYTE_IDX_WIDTH  = $clog2(PATTERN_BYTES);

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic                   is_total;
        logic [VALUE_WIDTH-1:0] value;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hw/rtl/lsmc_cell.sv =====
module lsmc_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  logic       clear,
    input  logic       used,
    input  logic [7:0] want,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = '0;
        end else if (shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // compare the byte that enters this position on the current shift
    assign hit      = !used || (byte_in == want);
    assign byte_out = byte_reg;

endmodule

// ===== hw/rtl/lsmc_result_fifo.sv =====
module lsmc_result_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lsmc_pkg::push_t        push,
    output logic                   room,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output lsmc_pkg::result_t      head
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    lsmc_pkg::result_t mem [DEPTH];

    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign head     = mem[rptr_reg];
    assign room     = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        wptr_next  = wptr_reg + PW'(push.n);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            mem[wptr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/line_substring_match_counter.sv =====
// Fixed-string line matcher: text enters one byte per transaction on the s_ stream
// (s_tuser high marks end of file, s_tdata ignored) and the block takes one byte every
// cycle while its result queue has room (s_tready high). The last
// MAX_PATTERN bytes sit in a row of shift cells, each comparing its incoming byte
// with its pattern byte, so a match is known in the cycle the byte arrives. Each
// matching line gives its 1-based line number on the m_ stream (m_tuser low); an
// end-of-file transaction closes an open line and then gives the count of words that
// contain the pattern (m_tuser high, m_tlast high), after which the block starts a
// new file. A four-entry result queue decouples the output; s_tready drops only while
// it holds more than two results. The user must write the cfg_ channel (index 0
// pattern bytes, index 1 pattern length) only while idle; the block does not check.
module line_substring_match_counter #(
    parameter int MAX_PATTERN = lsmc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_WIDTH = lsmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tuser,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value
    output logic        m_tuser,   // is_total
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LW = lsmc_pkg::LEN_WIDTH;
    localparam int BW = $clog2(MAX_PATTERN + 1);
    localparam int IW = lsmc_pkg::BYTE_IDX_WIDTH;
    localparam int VW = lsmc_pkg::VALUE_WIDTH;

    logic [lsmc_pkg::PATTERN_WIDTH-1:0] pattern_reg;
    logic [LW-1:0]                      plen_reg;

    logic [BW-1:0]          bil_reg, bil_next;
    logic [BW-1:0]          biw_reg, biw_next;
    logic                   lhm_reg, lhm_next;
    logic                   whm_reg, whm_next;
    logic                   open_reg, open_next;
    logic [COUNT_WIDTH-1:0] lines_reg, lines_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    logic [LW-1:0]          len;
    logic                   accept;
    logic                   shift;
    logic                   clear;
    logic                   match;
    logic                   room;
    logic [COUNT_WIDTH-1:0] lines_inc;
    logic [COUNT_WIDTH-1:0] total_inc;
    logic [VW-1:0]          total_val;
    logic [VW-1:0]          lines_inc_val;
    lsmc_pkg::push_t        push;
    lsmc_pkg::result_t      head;

    logic [7:0]       win  [MAX_PATTERN];
    logic [7:0]       want [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] used;
    logic [MAX_PATTERN-1:0] hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= LW'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lsmc_pkg::REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                lsmc_pkg::REG_PATTERN_LENGTH: plen_reg    <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (plen_reg == '0) begin
            len = LW'(1);
        end else if (plen_reg > LW'(MAX_PATTERN)) begin
            len = LW'(MAX_PATTERN);
        end else begin
            len = plen_reg;
        end
    end

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign shift    = accept && !s_tuser;
    assign clear    = accept && s_tuser;

    // cell k holds the byte of age k and checks it against pattern byte len-1-k
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [LW-1:0] pos;
        assign used[k] = (LW'(k) < len);
        assign pos     = len - LW'(1) - LW'(k);
        assign want[k] = pattern_reg[8 * pos[IW-1:0] +: 8];

        lsmc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift    (shift),
            .clear    (clear),
            .used     (used[k]),
            .want     (want[k]),
            .byte_in  ((k == 0) ? s_tdata : win[(k == 0) ? 0 : k - 1]),
            .byte_out (win[k]),
            .hit      (hit[k])
        );
    end

    assign match = &hit;

    assign lines_inc = (lines_reg == '1) ? lines_reg : lines_reg + COUNT_WIDTH'(1);
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + COUNT_WIDTH'(1);

    assign lines_inc_val = VW'(64'(lines_inc));
    assign total_val     = VW'(64'(total_reg));

    always_comb begin
        bil_next   = bil_reg;
        biw_next   = biw_reg;
        lhm_next   = lhm_reg;
        whm_next   = whm_reg;
        open_next  = open_reg;
        lines_next = lines_reg;
        total_next = total_reg;
        push       = '0;

        if (clear) begin
            if (open_reg && lhm_reg) begin
                push.n      = 2'd2;
                push.first  = '{is_total: 1'b0, value: lines_inc_val, last: 1'b0};
                push.second = '{is_total: 1'b1, value: total_val, last: 1'b1};
            end else begin
                push.n      = 2'd1;
                push.first  = '{is_total: 1'b1, value: total_val, last: 1'b1};
            end
            bil_next   = '0;
            biw_next   = '0;
            lhm_next   = 1'b0;
            whm_next   = 1'b0;
            open_next  = 1'b0;
            lines_next = '0;
            total_next = '0;
        end else if (shift) begin
            open_next = 1'b1;
            if (bil_reg != BW'(MAX_PATTERN)) begin
                bil_next = bil_reg + BW'(1);
            end
            if (s_tdata == lsmc_pkg::CHAR_SPACE) begin
                biw_next = '0;
                whm_next = 1'b0;
            end else if (biw_reg != BW'(MAX_PATTERN)) begin
                biw_next = biw_reg + BW'(1);
            end

            if (match) begin
                if (LW'(bil_next) >= len) begin
                    lhm_next = 1'b1;
                end
                if ((LW'(biw_next) >= len) && !whm_next) begin
                    whm_next   = 1'b1;
                    total_next = total_inc;
                end
            end

            if (s_tdata == lsmc_pkg::CHAR_NEWLINE) begin
                lines_next = lines_inc;
                if (lhm_next) begin
                    push.n     = 2'd1;
                    push.first = '{is_total: 1'b0, value: lines_inc_val, last: 1'b1};
                end
                bil_next  = '0;
                biw_next  = '0;
                lhm_next  = 1'b0;
                whm_next  = 1'b0;
                open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bil_reg   <= '0;
            biw_reg   <= '0;
            lhm_reg   <= 1'b0;
            whm_reg   <= 1'b0;
            open_reg  <= 1'b0;
            lines_reg <= '0;
            total_reg <= '0;
        end else begin
            bil_reg   <= bil_next;
            biw_reg   <= biw_next;
            lhm_reg   <= lhm_next;
            whm_reg   <= whm_next;
            open_reg  <= open_next;
            lines_reg <= lines_next;
            total_reg <= total_next;
        end
    end

    lsmc_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.value;
    assign m_tuser = head.is_total;
    assign m_tlast = head.last;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned WORD_MAX = lsmc_pkg::MAX_PATTERN_DEF;

    typedef struct packed {
        logic [7:0] text;
        logic       eof;
    } text_item_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = lsmc_pkg::REG_PATTERN_BYTES;
    logic [63:0] cfg_data  = 64'h0;

    line_substring_match_counter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    text_item_t          text_queue[$];
    lsmc_pkg::result_t   pending_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;

    // scanner copy: configuration
    logic [63:0] pat_bytes = 64'h0;
    logic [3:0]  pat_len   = 4'd1;

    // scanner copy: per-file state
    logic [63:0] history    = 64'h0;
    int unsigned line_fill  = 0;
    int unsigned word_fill  = 0;
    bit          line_hit   = 1'b0;
    bit          word_hit   = 1'b0;
    bit          in_line    = 1'b0;
    logic [31:0] lines_seen = 32'd0;
    logic [31:0] hit_words  = 32'd0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned active_len();
        if (pat_len == 4'd0)
            return 1;
        if (pat_len > WORD_MAX)
            return WORD_MAX;
        return pat_len;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic void scan_item(input logic [7:0] ch, input logic eof);
        int unsigned len;
        int unsigned i;
        bit hit;
        len = active_len();
        if (eof) begin
            if (in_line) begin
                lines_seen = bump(lines_seen);
                if (line_hit)
                    pending_results.push_back('{1'b0, lines_seen, 1'b0});
            end
            pending_results.push_back('{1'b1, hit_words, 1'b1});
            history = 64'h0;
            line_fill = 0;
            word_fill = 0;
            line_hit = 1'b0;
            word_hit = 1'b0;
            in_line = 1'b0;
            lines_seen = 32'd0;
            hit_words = 32'd0;
            return;
        end
        history = {history[55:0], ch};
        in_line = 1'b1;
        if (line_fill < WORD_MAX)
            line_fill++;
        if (ch == lsmc_pkg::CHAR_SPACE) begin
            word_fill = 0;
            word_hit = 1'b0;
        end else if (word_fill < WORD_MAX) begin
            word_fill++;
        end
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
            if (history[8*(len-1-i) +: 8] != pat_bytes[8*i +: 8])
                hit = 1'b0;
        end
        if (hit) begin
            if (line_fill >= len)
                line_hit = 1'b1;
            if (word_fill >= len && !word_hit) begin
                word_hit = 1'b1;
                hit_words = bump(hit_words);
            end
        end
        if (ch == lsmc_pkg::CHAR_NEWLINE) begin
            lines_seen = bump(lines_seen);
            if (line_hit)
                pending_results.push_back('{1'b0, lines_seen, 1'b1});
            line_fill = 0;
            word_fill = 0;
            line_hit = 1'b0;
            word_hit = 1'b0;
            in_line = 1'b0;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        text_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item = text_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= item.text;
                s_tuser <= item.eof;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        lsmc_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                scan_item(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: is_total=%0d value=%0d last=%0d",
                                 m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.is_total || m_tdata !== want.value
                            || m_tlast !== want.last) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected is_total=%0d value=%0d last=%0d,",
                                      " got is_total=%0d value=%0d last=%0d"},
                                     want.is_total, want.value, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic idx, input logic [63:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == lsmc_pkg::REG_PATTERN_BYTES)
            pat_bytes = data;
        else
            pat_len = data[3:0];
        @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] ch);
        text_queue.push_back('{ch, 1'b0});
    endtask

    task automatic push_eof();
        text_queue.push_back('{8'($urandom), 1'b1});
    endtask

    task automatic drain();
        while (text_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly text built around the pattern, with broken copies and noise
    task automatic queue_text(input int unsigned count);
        int unsigned eff;
        int unsigned pick;
        int unsigned cut;
        int unsigned k;
        int unsigned i;
        eff = active_len();
        k = 0;
        while (k < count) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                cut = (pick < 5) ? $urandom_range(eff) : eff;
                for (i = 0; i < cut; i++)
                    push_byte(pat_bytes[8*i +: 8]);
                k += (cut == 0) ? 1 : cut;
            end else if (pick < 34) begin
                push_byte(lsmc_pkg::CHAR_NEWLINE);
                k++;
            end else if (pick < 48) begin
                push_byte(lsmc_pkg::CHAR_SPACE);
                k++;
            end else if (pick < 86) begin
                push_byte(pat_bytes[8*$urandom_range(eff-1) +: 8]);
                k++;
            end else if (pick < 99) begin
                push_byte(8'($urandom));
                k++;
            end else begin
                push_eof();
                k++;
            end
        end
    endtask

    task automatic run_phase(input logic [63:0] pattern, input logic [3:0] len,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned count, input bit hold_midway);
        write_reg(lsmc_pkg::REG_PATTERN_BYTES, pattern);
        write_reg(lsmc_pkg::REG_PATTERN_LENGTH, 64'(len));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold_midway) begin
            queue_text(count / 2);
            while (text_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
                @(posedge aclk);
            queue_text(count - count / 2);
        end else begin
            queue_text(count);
        end
        push_eof();
        drain();
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed file: match, no match, eof on open matching line, empty file
        write_reg(lsmc_pkg::REG_PATTERN_BYTES, 64'h6261);
        write_reg(lsmc_pkg::REG_PATTERN_LENGTH, 64'd2);
        push_byte(8'h61);
        push_byte(8'h62);
        push_byte(lsmc_pkg::CHAR_NEWLINE);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h71);
        push_byte(lsmc_pkg::CHAR_NEWLINE);
        push_byte(lsmc_pkg::CHAR_SPACE);
        push_byte(8'h78);
        push_byte(8'h61);
        push_byte(8'h62);
        push_eof();
        push_eof();
        drain();

        run_phase({$urandom, $urandom}, 4'd1, 0, 0, 160, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 62, 0, 160, 1'b0);
        run_phase(64'h0, 4'd0, 0, 62, 160, 1'b0);
        run_phase({$urandom, $urandom}, 4'd15, 24, 24, 160, 1'b0);
        // newline as final pattern byte
        run_phase({48'($urandom), 8'h0A, 8'h78}, 4'd2, 0, 0, 160, 1'b0);
        // space inside the pattern
        run_phase({40'($urandom), 8'h62, 8'h20, 8'h61}, 4'd3, 62, 0, 160, 1'b0);
        // newline in the middle of the pattern
        run_phase({40'($urandom), 8'h62, 8'h0A, 8'h61}, 4'd3, 0, 62, 160, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(8, 1)), 24, 24, 160, 1'b1);
        run_phase({$urandom, $urandom}, 4'd8, 0, 0, 160, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(8, 1)), 62, 0, 160, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(8, 1)), 0, 62, 160, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(8, 1)), 24, 24, 160, 1'b0);

        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lsmc_pkg.sv
hw/rtl/lsmc_cell.sv
hw/rtl/lsmc_result_fifo.sv
hw/rtl/line_substring_match_counter.sv
dv/tb_top.sv
